>>> rtl/core/lkst_pkg.sv
// shared types, constants and lookup tables of the key scancode translator
package lkst_pkg;

	localparam int KeyCodes = 256;
	localparam int KeyW = $clog2(KeyCodes);
	localparam int MaxRes = 4;
	localparam int ResIdxW = $clog2(MaxRes);
	localparam int ResCntW = $clog2(MaxRes + 1);

	localparam logic [7:0] NO_CODE = 8'hff;
	localparam logic [7:0] KANA_CODE = 8'h72;
	localparam logic [7:0] PREFIX_CODE = 8'h70;
	localparam logic [7:0] BREAK_BIT = 8'h80;
	localparam logic [7:0] CLEAR_KEY_CODE = 8'h47;
	localparam logic [KeyW-1:0] CLEAR_KEY = 8'h0c;
	localparam logic [KeyW-1:0] LETTER_LO = 8'h41;
	localparam logic [KeyW-1:0] LETTER_HI = 8'h5a;
	localparam logic [KeyW-1:0] KEY_SHIFT = 8'h10;
	localparam logic [KeyW-1:0] KEY_CTRL = 8'h11;
	localparam logic [KeyW-1:0] KEY_ALT = 8'h12;
	localparam logic [7:0] LAYER_KEY_RST = 8'h7a;

	localparam int RegRomaji = 0;
	localparam int RegLayerKey = 1;

	typedef enum logic [1:0] {
		KIND_SCAN   = 2'd0,
		KIND_LETTER = 2'd1,
		KIND_CLEAR  = 2'd2
	} kind_t;

	localparam logic [7:0] BASE_TABLE [KeyCodes] = '{
		8'hff,8'hff,8'hff,8'h60,8'hff,8'hff,8'hff,8'hff,
		8'h0e,8'h0f,8'hff,8'hff,8'hff,8'h1c,8'hff,8'hff,
		8'h70,8'h74,8'h73,8'h60,8'h70,8'h72,8'hff,8'hff,
		8'hff,8'hff,8'hff,8'h00,8'h35,8'h51,8'hff,8'hff,
		8'h34,8'h37,8'h36,8'h3f,8'h3e,8'h3b,8'h3a,8'h3c,
		8'h3d,8'hff,8'hff,8'hff,8'hff,8'h38,8'h39,8'hff,
		8'h0a,8'h01,8'h02,8'h03,8'h04,8'h05,8'h06,8'h07,
		8'h08,8'h09,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
		8'hff,8'h1d,8'h2d,8'h2b,8'h1f,8'h12,8'h20,8'h21,
		8'h22,8'h17,8'h23,8'h24,8'h25,8'h2f,8'h2e,8'h18,
		8'h19,8'h10,8'h13,8'h1e,8'h14,8'h16,8'h2c,8'h11,
		8'h2a,8'h15,8'h29,8'hff,8'hff,8'hff,8'hff,8'hff,
		8'h4e,8'h4a,8'h4b,8'h4c,8'h46,8'h47,8'h48,8'h42,
		8'h43,8'h44,8'h45,8'h49,8'hff,8'h40,8'h50,8'h41,
		8'h62,8'h63,8'h64,8'h65,8'h66,8'h67,8'h66,8'h69,
		8'h6a,8'h6b,8'hff,8'h72,8'hff,8'hff,8'hff,8'hff,
		8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
		8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
		8'hff,8'h73,8'h4d,8'hff,8'hff,8'hff,8'hff,8'hff,
		8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
		8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
		8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
		8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
		8'hff,8'hff,8'h27,8'h26,8'h30,8'h0b,8'h31,8'h32,
		8'h1a,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
		8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
		8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
		8'hff,8'hff,8'hff,8'h1b,8'h0d,8'h28,8'h0c,8'hff,
		8'hff,8'hff,8'h33,8'hff,8'hff,8'hff,8'hff,8'hff,
		8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,
		8'h71,8'hff,8'h72,8'hff,8'hff,8'hff,8'hff,8'hff,
		8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff,8'hff
	};

	function automatic logic [7:0] sym_code(input logic [KeyW-1:0] key);
		logic [7:0] c;
		c = BASE_TABLE[key];
		case (key)
			8'h51: c = 8'h01;
			8'h57: c = 8'h02;
			8'h45: c = 8'h03;
			8'h52: c = 8'h04;
			8'h54: c = 8'h05;
			8'h59: c = 8'h06;
			8'h55: c = 8'h07;
			8'h49: c = 8'h08;
			8'h4f: c = 8'h09;
			8'h50: c = 8'h0a;
			8'h44: c = 8'h0c;
			8'h46: c = 8'h0d;
			8'h47: c = 8'h1a;
			8'h48: c = 8'h1b;
			8'h4a: c = 8'h26;
			8'h4b: c = 8'h27;
			8'h4c: c = 8'h28;
			8'h56: c = 8'h30;
			8'h42: c = 8'h31;
			8'h4e: c = 8'h32;
			8'h4d: c = 8'h33;
			default: ;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] pad_code(input logic [KeyW-1:0] key);
		logic [7:0] c;
		c = sym_code(key);
		case (key)
			8'h51: c = 8'h4a;
			8'h57: c = 8'h4b;
			8'h45: c = 8'h4c;
			8'h52: c = 8'h46;
			8'h54: c = 8'h47;
			8'h59: c = 8'h48;
			8'h55: c = 8'h42;
			8'h49: c = 8'h43;
			8'h4f: c = 8'h44;
			8'h50: c = 8'h4e;
			default: ;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] alt_code(input logic [KeyW-1:0] key);
		logic [7:0] c;
		c = NO_CODE;
		case (key)
			8'h21: c = 8'h44;
			8'h22: c = 8'h4c;
			8'h23: c = 8'h4a;
			8'h24: c = 8'h42;
			8'h25: c = 8'h46;
			8'h26: c = 8'h43;
			8'h27: c = 8'h48;
			8'h28: c = 8'h4b;
			8'h2d: c = 8'h4e;
			8'h2e: c = 8'h50;
			default: ;
		endcase
		return c;
	endfunction

endpackage

>>> rtl/core/lkst_if.sv
// event and result channel interfaces
interface lkst_evt_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] vkey;
	logic       is_repeat;
	logic       is_extended;
	modport source(output valid, req_type, vkey, is_repeat, is_extended, input ready);
	modport sink(input valid, req_type, vkey, is_repeat, is_extended, output ready);
endinterface

interface lkst_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] out_kind;
	logic [7:0] out_byte;
	logic       last;
	modport source(output valid, out_kind, out_byte, last, input ready);
	modport sink(input valid, out_kind, out_byte, last, output ready);
endinterface

>>> rtl/core/layered_key_scancode_translator_top.sv
// Key event to scan byte translator. An event is taken into an input register, translated
// combinationally into up to four results held in a result buffer, and the results leave one
// per cycle on the result channel while it is ready. The next event is taken while the
// results of the previous one drain; the single result channel sets the sustained rate.
// Registers: romaji_mode at 0x0, layer_toggle_key at 0x4.
module layered_key_scancode_translator_top (
	input  logic        clk,
	input  logic        arst_n,
	lkst_evt_if.sink    evt,
	lkst_res_if.source  res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import lkst_pkg::*;

	logic romaji_q;
	logic [7:0] layer_key_q;
	logic kana_q, layer_q;

	logic ev_valid_s1, ev_rel_s1, ev_rep_s1, ev_ext_s1;
	logic [KeyW-1:0] ev_key_s1;

	kind_t kind_q [MaxRes];
	logic [7:0] byte_q [MaxRes];
	logic [ResCntW-1:0] cnt_q;
	logic [ResIdxW-1:0] idx_q;

	kind_t kind_n [MaxRes];
	logic [7:0] byte_n [MaxRes];
	logic [ResCntW-1:0] n;
	logic kana_n, layer_n;

	logic wr, res_xfer, res_done, load;
	logic [7:0] data, alt, brk;
	logic route, letter, modifier;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	always_comb begin
		prdata = '0;
		if (paddr == 3'(4 * RegRomaji)) begin
			prdata = 32'(romaji_q);
		end else if (paddr == 3'(4 * RegLayerKey)) begin
			prdata = 32'(layer_key_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			romaji_q <= 1'b1;
			layer_key_q <= LAYER_KEY_RST;
		end else if (wr) begin
			if (paddr == 3'(4 * RegRomaji)) begin
				romaji_q <= pwdata[0];
			end else if (paddr == 3'(4 * RegLayerKey)) begin
				layer_key_q <= pwdata[7:0];
			end
		end
	end

	assign res.valid = cnt_q != '0;
	assign res.out_kind = kind_q[idx_q];
	assign res.out_byte = byte_q[idx_q];
	assign res.last = ResCntW'(idx_q) + 1'b1 == cnt_q;
	assign res_xfer = res.valid && res.ready;
	assign res_done = !res.valid || (res_xfer && res.last);
	assign load = ev_valid_s1 && res_done;
	assign evt.ready = !ev_valid_s1 || res_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			ev_valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.ready && evt.valid) begin
			ev_rel_s1 <= evt.req_type;
			ev_key_s1 <= evt.vkey;
			ev_rep_s1 <= evt.is_repeat;
			ev_ext_s1 <= evt.is_extended;
		end
	end

	// translation of the held event
	always_comb begin
		n = '0;
		for (int i = 0; i < MaxRes; i++) begin
			kind_n[i] = KIND_SCAN;
			byte_n[i] = '0;
		end
		kana_n = kana_q;
		layer_n = layer_q;
		letter = ev_key_s1 >= LETTER_LO && ev_key_s1 <= LETTER_HI;
		modifier = ev_key_s1 == KEY_SHIFT || ev_key_s1 == KEY_CTRL || ev_key_s1 == KEY_ALT;
		brk = ev_rel_s1 ? BREAK_BIT : 8'h00;
		alt = alt_code(ev_key_s1);
		if (ev_rel_s1 && ev_key_s1 == layer_key_q) begin
			layer_n = !layer_q;
			kind_n[n[ResIdxW-1:0]] = KIND_CLEAR;
			n = n + 1'b1;
		end
		if (!layer_n) begin
			data = BASE_TABLE[ev_key_s1];
		end else if (romaji_q && kana_q) begin
			data = pad_code(ev_key_s1);
		end else begin
			data = sym_code(ev_key_s1);
		end
		if (!ev_rel_s1 && data == KANA_CODE && !ev_rep_s1) begin
			kana_n = !kana_q;
			kind_n[n[ResIdxW-1:0]] = KIND_CLEAR;
			n = n + 1'b1;
		end
		route = romaji_q && kana_n && !layer_n && data != NO_CODE;
		if (!(route && letter)) begin
			if (route && !ev_rel_s1 && !modifier) begin
				kind_n[n[ResIdxW-1:0]] = KIND_CLEAR;
				n = n + 1'b1;
			end
			if (data != NO_CODE) begin
				if (!ev_ext_s1 && alt != NO_CODE) begin
					byte_n[n[ResIdxW-1:0]] = PREFIX_CODE | brk;
					n = n + 1'b1;
					byte_n[n[ResIdxW-1:0]] = alt | brk;
				end else begin
					byte_n[n[ResIdxW-1:0]] = data | brk;
				end
				n = n + 1'b1;
			end else if (ev_key_s1 == CLEAR_KEY) begin
				byte_n[n[ResIdxW-1:0]] = PREFIX_CODE | brk;
				n = n + 1'b1;
				byte_n[n[ResIdxW-1:0]] = CLEAR_KEY_CODE | brk;
				n = n + 1'b1;
			end
		end else if (!ev_rel_s1) begin
			kind_n[n[ResIdxW-1:0]] = KIND_LETTER;
			byte_n[n[ResIdxW-1:0]] = ev_key_s1;
			n = n + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kana_q <= 1'b0;
			layer_q <= 1'b0;
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			kana_q <= kana_n;
			layer_q <= layer_n;
			cnt_q <= n;
			idx_q <= '0;
		end else if (res_xfer) begin
			if (res.last) begin
				cnt_q <= '0;
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= kind_n;
			byte_q <= byte_n;
		end
	end

endmodule

>>> test/layered_key_scancode_translator_top_test.sv
// testbench of the key scancode translator: directed table, random events, self-checking
`timescale 1ns / 1ps
module layered_key_scancode_translator_top_test;
	import lkst_pkg::*;

	typedef struct packed {
		logic       req_type;
		logic [7:0] vkey;
		logic       is_repeat;
		logic       is_extended;
	} key_evt_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] code;
		logic       last;
	} scan_res_t;

	typedef struct {
		key_evt_t ev;
		int       n;
		scan_res_t r0;
		scan_res_t r1;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;

	lkst_evt_if evt();
	lkst_res_if res();

	layered_key_scancode_translator_top dut (
		.clk(clk), .arst_n(arst_n), .evt(evt.sink), .res(res.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	scan_res_t pending_scans[$];
	bit kana_on, layer_on, romaji_on;
	logic [7:0] layer_key;
	int errors;
	int n_events, n_results, n_letters, n_clears;
	bit src_idle_ok, snk_idle_ok, hold_sink;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Test completed with failures");
		$finish;
	end

	function automatic logic [7:0] layered_code(logic [7:0] k);
		if (!layer_on) return BASE_TABLE[k];
		if (romaji_on && kana_on) begin
			case (k)
				8'h51: return 8'h4a; 8'h57: return 8'h4b; 8'h45: return 8'h4c;
				8'h52: return 8'h46; 8'h54: return 8'h47; 8'h59: return 8'h48;
				8'h55: return 8'h42; 8'h49: return 8'h43; 8'h4f: return 8'h44;
				8'h50: return 8'h4e;
				default: ;
			endcase
		end
		case (k)
			8'h51: return 8'h01; 8'h57: return 8'h02; 8'h45: return 8'h03;
			8'h52: return 8'h04; 8'h54: return 8'h05; 8'h59: return 8'h06;
			8'h55: return 8'h07; 8'h49: return 8'h08; 8'h4f: return 8'h09;
			8'h50: return 8'h0a; 8'h44: return 8'h0c; 8'h46: return 8'h0d;
			8'h47: return 8'h1a; 8'h48: return 8'h1b; 8'h4a: return 8'h26;
			8'h4b: return 8'h27; 8'h4c: return 8'h28; 8'h56: return 8'h30;
			8'h42: return 8'h31; 8'h4e: return 8'h32; 8'h4d: return 8'h33;
			default: return BASE_TABLE[k];
		endcase
	endfunction

	function automatic logic [7:0] prefixed_code(logic [7:0] k);
		case (k)
			8'h21: return 8'h44; 8'h22: return 8'h4c; 8'h23: return 8'h4a;
			8'h24: return 8'h42; 8'h25: return 8'h46; 8'h26: return 8'h43;
			8'h27: return 8'h48; 8'h28: return 8'h4b; 8'h2d: return 8'h4e;
			8'h2e: return 8'h50;
			default: return NO_CODE;
		endcase
	endfunction

	task automatic translate_event(input key_evt_t e, output scan_res_t r[$]);
		logic [7:0] d, brk;
		bit letter, route;
		r = {};
		letter = (e.vkey >= LETTER_LO) && (e.vkey <= LETTER_HI);
		brk = e.req_type ? BREAK_BIT : 8'h00;
		if (!e.req_type) begin
			d = layered_code(e.vkey);
			if (d == KANA_CODE && !e.is_repeat) begin
				kana_on = !kana_on;
				r.push_back('{KIND_CLEAR, 8'h00, 1'b0});
			end
		end else begin
			if (e.vkey == layer_key) begin
				layer_on = !layer_on;
				r.push_back('{KIND_CLEAR, 8'h00, 1'b0});
			end
			d = layered_code(e.vkey);
		end
		route = romaji_on && kana_on && !layer_on && d != NO_CODE;
		if (route && letter) begin
			if (!e.req_type) r.push_back('{KIND_LETTER, e.vkey, 1'b0});
		end else begin
			if (route && !e.req_type && e.vkey != KEY_SHIFT && e.vkey != KEY_CTRL
					&& e.vkey != KEY_ALT)
				r.push_back('{KIND_CLEAR, 8'h00, 1'b0});
			if (d != NO_CODE) begin
				if (!e.is_extended && prefixed_code(e.vkey) != NO_CODE) begin
					r.push_back('{KIND_SCAN, PREFIX_CODE | brk, 1'b0});
					d = prefixed_code(e.vkey);
				end
				r.push_back('{KIND_SCAN, d | brk, 1'b0});
			end else if (e.vkey == CLEAR_KEY) begin
				r.push_back('{KIND_SCAN, PREFIX_CODE | brk, 1'b0});
				r.push_back('{KIND_SCAN, CLEAR_KEY_CODE | brk, 1'b0});
			end
		end
		if (r.size() > 0) r[r.size()-1].last = 1'b1;
	endtask

	task automatic reg_write(input int idx, input logic [31:0] v);
		logic [31:0] want;
		want = (idx == RegRomaji) ? 32'(v[0]) : 32'(v[7:0]);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= 3'(idx * 4); pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (idx == RegRomaji) romaji_on = v[0];
		else layer_key = v[7:0];
		@(posedge clk);
		if (pready !== 1'b1) begin
			$error("pready expected 1 actual %b", pready);
			errors++;
		end
		if (prdata !== want) begin
			$error("prdata expected %h actual %h", want, prdata);
			errors++;
		end
	endtask

	task automatic drain_all();
		while (pending_scans.size() > 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic send_event(input key_evt_t e);
		scan_res_t r[$];
		if (src_idle_ok && $urandom_range(0, 5) == 0) begin
			evt.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		evt.valid <= 1'b1;
		{evt.req_type, evt.vkey, evt.is_repeat, evt.is_extended} <= e;
		@(posedge clk);
		while (!evt.ready) @(posedge clk);
		translate_event(e, r);
		foreach (r[i]) pending_scans.push_back(r[i]);
		n_events++;
	endtask

	task automatic idle_source();
		evt.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic key_evt_t random_event();
		key_evt_t e;
		int sel;
		sel = $urandom_range(0, 9);
		e.req_type = 1'($urandom_range(0, 1));
		e.is_repeat = ($urandom_range(0, 3) == 0);
		e.is_extended = ($urandom_range(0, 3) == 0);
		case (sel)
			0, 1, 2: e.vkey = 8'($urandom_range(LETTER_LO, LETTER_HI));
			3: e.vkey = layer_key;
			4: e.vkey = ($urandom_range(0, 1)) ? 8'h15 : 8'h7b;
			5: e.vkey = 8'($urandom_range(8'h21, 8'h2e));
			6: e.vkey = 8'($urandom_range(KEY_SHIFT, KEY_ALT));
			7: e.vkey = CLEAR_KEY;
			default: e.vkey = 8'($urandom_range(0, 255));
		endcase
		return e;
	endfunction

	// result checker
	always @(posedge clk) begin
		scan_res_t got, want;
		if (arst_n && res.valid && res.ready) begin
			got = '{res.out_kind, res.out_byte, res.last};
			if (pending_scans.size() == 0) begin
				$error("unexpected result kind %0d byte %h", got.kind, got.code);
				errors++;
			end else begin
				want = pending_scans.pop_front();
				if (got.kind !== want.kind) begin
					$error("out_kind expected %0d actual %0d", want.kind, got.kind);
					errors++;
				end
				if (got.code !== want.code) begin
					$error("out_byte expected %h actual %h", want.code, got.code);
					errors++;
				end
				if (got.last !== want.last) begin
					$error("last expected %0d actual %0d", want.last, got.last);
					errors++;
				end
				n_results++;
				if (want.kind == KIND_LETTER) n_letters++;
				if (want.kind == KIND_CLEAR) n_clears++;
			end
		end
	end

	// result side backpressure
	initial begin
		res.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_sink) res.ready <= 1'b0;
			else if (snk_idle_ok && $urandom_range(0, 5) == 0) begin
				res.ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				res.ready <= 1'b1;
			end else res.ready <= 1'b1;
		end
	end

	initial begin
		dir_row_t rows[$];
		scan_res_t r[$];
		key_evt_t e;
		bit kana_sv, layer_sv;
		evt.valid = 1'b0; evt.req_type = 1'b0; evt.vkey = '0;
		evt.is_repeat = 1'b0; evt.is_extended = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		errors = 0; n_events = 0; n_results = 0; n_letters = 0; n_clears = 0;
		kana_on = 0; layer_on = 0; romaji_on = 1; layer_key = LAYER_KEY_RST;
		src_idle_ok = 1; snk_idle_ok = 1; hold_sink = 0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// n < 0 means check against the predictor only
		rows = '{
			'{'{1'b0, 8'h41, 1'b0, 1'b0}, 1, '{KIND_SCAN, 8'h1d, 1'b1}, '0},
			'{'{1'b1, 8'h41, 1'b1, 1'b0}, 1, '{KIND_SCAN, 8'h9d, 1'b1}, '0},
			'{'{1'b0, 8'h00, 1'b0, 1'b0}, 0, '0, '0},
			'{'{1'b1, 8'hff, 1'b0, 1'b1}, 0, '0, '0},
			'{'{1'b0, 8'h0c, 1'b0, 1'b0}, 2, '{KIND_SCAN, 8'h70, 1'b0},
				'{KIND_SCAN, 8'h47, 1'b1}},
			'{'{1'b1, 8'h0c, 1'b0, 1'b1}, 2, '{KIND_SCAN, 8'hf0, 1'b0},
				'{KIND_SCAN, 8'hc7, 1'b1}},
			'{'{1'b0, 8'h21, 1'b0, 1'b0}, 2, '{KIND_SCAN, 8'h70, 1'b0},
				'{KIND_SCAN, 8'h44, 1'b1}},
			'{'{1'b0, 8'h21, 1'b0, 1'b1}, 1, '{KIND_SCAN, 8'h37, 1'b1}, '0},
			'{'{1'b0, 8'h15, 1'b1, 1'b0}, 1, '{KIND_SCAN, 8'h72, 1'b1}, '0},
			'{'{1'b0, 8'h15, 1'b0, 1'b0}, -1, '0, '0},
			'{'{1'b0, 8'h5a, 1'b0, 1'b0}, -1, '0, '0},
			'{'{1'b1, 8'h5a, 1'b0, 1'b0}, -1, '0, '0},
			'{'{1'b0, 8'h10, 1'b0, 1'b0}, -1, '0, '0},
			'{'{1'b0, 8'h0d, 1'b0, 1'b0}, -1, '0, '0},
			'{'{1'b0, 8'h21, 1'b0, 1'b0}, -1, '0, '0},
			'{'{1'b1, 8'h7a, 1'b0, 1'b0}, -1, '0, '0},
			'{'{1'b0, 8'h51, 1'b0, 1'b0}, -1, '0, '0},
			'{'{1'b0, 8'h44, 1'b0, 1'b0}, -1, '0, '0},
			'{'{1'b0, 8'h7b, 1'b0, 1'b0}, -1, '0, '0},
			'{'{1'b1, 8'h7a, 1'b0, 1'b1}, -1, '0, '0},
			'{'{1'b0, 8'h12, 1'b1, 1'b1}, -1, '0, '0}
		};
		foreach (rows[i]) begin
			if (rows[i].n >= 0) begin
				kana_sv = kana_on;
				layer_sv = layer_on;
				translate_event(rows[i].ev, r);
				if (r.size() != rows[i].n ||
						(rows[i].n > 0 && r[0] != rows[i].r0) ||
						(rows[i].n > 1 && r[1] != rows[i].r1)) begin
					$error("directed row %0d: table disagrees with prediction", i);
					errors++;
				end
				kana_on = kana_sv;
				layer_on = layer_sv;
			end
			send_event(rows[i].ev);
		end
		idle_source();
		drain_all();

		// long result stall while events keep coming
		hold_sink = 1;
		fork
			begin
				repeat (200) @(posedge clk);
				hold_sink = 0;
			end
			for (int i = 0; i < 30; i++) send_event(random_event());
		join
		idle_source();
		drain_all();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin reg_write(RegRomaji, 32'd0); reg_write(RegLayerKey, 32'd0); end
				1: begin reg_write(RegRomaji, 32'd1); reg_write(RegLayerKey, 32'hff); end
				2: reg_write(RegLayerKey, 32'h41);
				3: begin reg_write(RegRomaji, 32'd0); reg_write(RegLayerKey, 32'h7a); end
				4: reg_write(RegRomaji, 32'd1);
				default: begin src_idle_ok = 0; snk_idle_ok = 0; end
			endcase
			for (int i = 0; i < 53; i++) begin
				e = random_event();
				send_event(e);
			end
			idle_source();
			drain_all();
		end

		$display("events %0d, results %0d (letters %0d, clears %0d), six register settings",
			n_events, n_results, n_letters, n_clears);
		$display("covered directed extremes, long result stall, layer and kana toggling");
		if (errors == 0 && pending_scans.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
